@@ rtl/edf_pkg.sv @@
// Shared types, widths and codes of the EDF periodic task scheduler.
package edf_pkg;

  localparam int MAX_TASKS    = 16;
  localparam int TASK_IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TICK_W       = 32;
  localparam int BURST_W      = 16;
  localparam int PERIOD_W     = 16;
  localparam int SLOT_W       = 4;
  localparam int TCOUNT_W     = 5;
  localparam int OUT_TASK_W   = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT  = 1'b1;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;
    logic update;
    logic charge;
    logic in_use;
  } cell_ctrl_t;

  // Earliest-deadline candidate handed along the cell row.
  typedef struct packed {
    logic                  valid;
    logic [TASK_IDX_W-1:0] idx;
    logic [TICK_W-1:0]     deadline;
  } cand_t;

endpackage

@@ rtl/edf_ifs.sv @@
// Handshake channel interfaces of the EDF periodic task scheduler.
interface edf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [edf_pkg::SLOT_W-1:0]   task_slot;
  logic [edf_pkg::BURST_W-1:0]  burst_length;
  logic [edf_pkg::PERIOD_W-1:0] period_length;

  modport source (output valid, op, task_slot, burst_length, period_length, input ready);
  modport sink   (input valid, op, task_slot, burst_length, period_length, output ready);
endinterface

interface edf_out_if;
  logic                           valid;
  logic                           ready;
  logic [edf_pkg::OUT_TASK_W-1:0] running_task;
  logic                           proc_idle;
  logic                           task_completed;
  logic                           deadline_missed;
  logic                           halted;

  modport source (output valid, running_task, proc_idle, task_completed, deadline_missed,
                  halted, input ready);
  modport sink   (input valid, running_task, proc_idle, task_completed, deadline_missed,
                  halted, output ready);
endinterface

interface edf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [edf_pkg::CFG_IDX_W-1:0]  index;
  logic [edf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/edf_cell.sv @@
// One task cell: holds a task's entry and passes the earliest-deadline candidate on.
module edf_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  edf_pkg::cell_ctrl_t             ctrl,
  input  logic [edf_pkg::TASK_IDX_W-1:0]  idx,
  input  logic [edf_pkg::BURST_W-1:0]     ld_burst,
  input  logic [edf_pkg::PERIOD_W-1:0]    ld_period,
  input  logic [edf_pkg::TICK_W-1:0]      tick_now,
  input  edf_pkg::cand_t                  cand_in,
  output edf_pkg::cand_t                  cand_out,
  output logic                            complete,
  output logic                            miss
);
  import edf_pkg::*;

  logic [BURST_W-1:0]  burst_r, burst_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [BURST_W-1:0]  rem_r, rem_nxt;
  logic [TICK_W-1:0]   dl_r, dl_nxt;
  logic                done_r, done_nxt;
  logic                done_now;
  cand_t               cand_r, cand_nxt;

  always_comb begin
    burst_nxt  = burst_r;
    period_nxt = period_r;
    rem_nxt    = rem_r;
    dl_nxt     = dl_r;
    done_nxt   = done_r;
    done_now   = done_r;
    complete   = 1'b0;
    miss       = 1'b0;
    if (ctrl.load) begin
      burst_nxt  = ld_burst;
      period_nxt = ld_period;
      rem_nxt    = ld_burst;
      dl_nxt     = TICK_W'(ld_period);
      done_nxt   = 1'b0;
    end else if (ctrl.update) begin
      // Charge the running task first; a finished burst reloads.
      if (ctrl.charge) begin
        if (rem_r <= BURST_W'(1)) begin
          complete = 1'b1;
          done_now = 1'b1;
          rem_nxt  = burst_r;
        end else begin
          rem_nxt = rem_r - BURST_W'(1);
        end
      end
      done_nxt = done_now;
      if (ctrl.in_use) begin
        if (done_now && (dl_r <= tick_now)) begin
          dl_nxt   = dl_r + TICK_W'(period_r);
          done_nxt = 1'b0;
        end else if (!done_now && (dl_r == tick_now)) begin
          miss = 1'b1;
        end
      end
    end
  end

  // The incoming candidate has a lower index, so it wins ties.
  always_comb begin
    cand_nxt = cand_in;
    if (ctrl.in_use && !done_r && (!cand_in.valid || (dl_r < cand_in.deadline))) begin
      cand_nxt.valid    = 1'b1;
      cand_nxt.idx      = idx;
      cand_nxt.deadline = dl_r;
    end
  end

  always_ff @(posedge clk) begin
    burst_r  <= burst_nxt;
    period_r <= period_nxt;
    rem_r    <= rem_nxt;
    dl_r     <= dl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
      cand_r <= '0;
    end else begin
      done_r <= done_nxt;
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

@@ rtl/edf_periodic_task_scheduler.sv @@
// Top level of the non-preemptive EDF periodic task scheduler.
//
// Usage: words arrive on in_ch. A load word (op = load) writes one task slot's
// burst and period and marks the task unfinished; a tick word advances time by one unless halted.
// Every input word produces exactly one result word on out_ch, in order.
// Registers task_count and run_limit are written through cfg_ch, whose ready is
// always high; write them only while the scheduler has no word in flight.
//
// Sequencing: a load word, or a tick while halted or on the halting tick, goes from
// idle straight to the emit state. A tick with a task still running after the
// charge passes through the update state to emit. A tick that needs a new choice
// passes through update, scan and pick: the earliest-deadline candidate walks the row of
// task cells one cell per clock, so the cell row length sets the scan length.
// One word is processed at a time; the next word is taken when the sequencer is
// back in its idle state, even while the previous result is still waiting.
//
// Reset: time starts at one, all tasks are done, nothing runs, and the halt is
// clear. If the receiver stalls, the result holds on out_ch and the sequencer
// waits before writing a new result.
module edf_periodic_task_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  edf_in_if.sink     in_ch,
  edf_out_if.source  out_ch,
  edf_cfg_if.sink    cfg_ch
);
  import edf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_PICK,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TICK_W-1:0]      tick_r, tick_nxt;
  logic [TICK_W-1:0]      tick_inc;
  logic [TCOUNT_W-1:0]    task_count_r, task_count_nxt;
  logic [TICK_W-1:0]      run_limit_r, run_limit_nxt;
  logic                   stop_r, stop_nxt;
  logic                   act_valid_r, act_valid_nxt;
  logic [TASK_IDX_W-1:0]  act_idx_r, act_idx_nxt;
  logic                   done_flag_r, done_flag_nxt;
  logic                   miss_flag_r, miss_flag_nxt;
  logic [TASK_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TASK_W-1:0]  out_task_r, out_task_nxt;
  logic                   out_idle_r, out_idle_nxt;
  logic                   out_done_r, out_done_nxt;
  logic                   out_miss_r, out_miss_nxt;
  logic                   out_halt_r, out_halt_nxt;

  logic                   in_acc;
  logic                   is_load;
  logic                   cell_update;
  logic [TASK_IDX_W+OUT_TASK_W-1:0] act_ext;

  cell_ctrl_t             ctrl [MAX_TASKS];
  cand_t                  cand_w [MAX_TASKS+1];
  logic [MAX_TASKS-1:0]   complete_v;
  logic [MAX_TASKS-1:0]   miss_v;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign is_load      = in_acc && (op_t'(in_ch.op) == OP_LOAD);
  assign cell_update  = (state_r == S_UPDATE);
  assign tick_inc     = tick_r + TICK_W'(1);
  assign act_ext      = {OUT_TASK_W'(0), act_idx_r};

  // Row of task cells; the candidate enters empty at the head of the row.
  assign cand_w[0] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    always_comb begin
      ctrl[i].load   = is_load && (32'(in_ch.task_slot) == 32'(i));
      ctrl[i].update = cell_update;
      ctrl[i].charge = act_valid_r && (32'(act_idx_r) == 32'(i));
      ctrl[i].in_use = (32'(i) < 32'(task_count_r));
    end

    edf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[i]),
      .idx       (TASK_IDX_W'(i)),
      .ld_burst  (in_ch.burst_length),
      .ld_period (in_ch.period_length),
      .tick_now  (tick_r),
      .cand_in   (cand_w[i]),
      .cand_out  (cand_w[i+1]),
      .complete  (complete_v[i]),
      .miss      (miss_v[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    task_count_nxt = task_count_r;
    run_limit_nxt  = run_limit_r;
    stop_nxt       = stop_r;
    act_valid_nxt  = act_valid_r;
    act_idx_nxt    = act_idx_r;
    done_flag_nxt  = done_flag_r;
    miss_flag_nxt  = miss_flag_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_task_nxt   = out_task_r;
    out_idle_nxt   = out_idle_r;
    out_done_nxt   = out_done_r;
    out_miss_nxt   = out_miss_r;
    out_halt_nxt   = out_halt_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_TASK_COUNT: task_count_nxt = cfg_ch.data[TCOUNT_W-1:0];
        CFG_RUN_LIMIT:  run_limit_nxt  = cfg_ch.data[TICK_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          done_flag_nxt = 1'b0;
          miss_flag_nxt = 1'b0;
          state_nxt     = S_EMIT;
          if (op_t'(in_ch.op) == OP_TICK && !stop_r) begin
            tick_nxt = tick_inc;
            if ((run_limit_r != '0) && (tick_inc == run_limit_r)) begin
              stop_nxt = 1'b1;
            end else begin
              state_nxt = S_UPDATE;
            end
          end
        end
      end
      S_UPDATE: begin
        done_flag_nxt = |complete_v;
        miss_flag_nxt = |miss_v;
        if (act_valid_r && !(|complete_v)) begin
          state_nxt = S_EMIT;
        end else begin
          act_valid_nxt = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // The scan holds until the candidate has passed every cell of the row.
        if (cnt_r == TASK_IDX_W'(MAX_TASKS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PICK;
        end else begin
          cnt_nxt = cnt_r + TASK_IDX_W'(1);
        end
      end
      S_PICK: begin
        act_valid_nxt = cand_w[MAX_TASKS].valid;
        act_idx_nxt   = cand_w[MAX_TASKS].valid ? cand_w[MAX_TASKS].idx : '0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_task_nxt  = act_valid_r ? act_ext[OUT_TASK_W-1:0] : '0;
          out_idle_nxt  = !act_valid_r;
          out_done_nxt  = done_flag_r;
          out_miss_nxt  = miss_flag_r;
          out_halt_nxt  = stop_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tick_r       <= TICK_W'(1);
      task_count_r <= TCOUNT_W'(1);
      run_limit_r  <= '0;
      stop_r       <= 1'b0;
      act_valid_r  <= 1'b0;
      act_idx_r    <= '0;
      done_flag_r  <= 1'b0;
      miss_flag_r  <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      out_task_r   <= '0;
      out_idle_r   <= 1'b1;
      out_done_r   <= 1'b0;
      out_miss_r   <= 1'b0;
      out_halt_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      task_count_r <= task_count_nxt;
      run_limit_r  <= run_limit_nxt;
      stop_r       <= stop_nxt;
      act_valid_r  <= act_valid_nxt;
      act_idx_r    <= act_idx_nxt;
      done_flag_r  <= done_flag_nxt;
      miss_flag_r  <= miss_flag_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_task_r   <= out_task_nxt;
      out_idle_r   <= out_idle_nxt;
      out_done_r   <= out_done_nxt;
      out_miss_r   <= out_miss_nxt;
      out_halt_r   <= out_halt_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.running_task    = out_task_r;
  assign out_ch.proc_idle       = out_idle_r;
  assign out_ch.task_completed  = out_done_r;
  assign out_ch.deadline_missed = out_miss_r;
  assign out_ch.halted          = out_halt_r;

  // Only reset clears a halt.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("halt flag cleared without reset");

  // A load word never changes the running task or the halt state.
  a_load_keeps_sched: assert property (@(posedge clk) disable iff (!rst_n)
    is_load |=> ($stable(act_valid_r) && $stable(act_idx_r) && $stable(stop_r)))
    else $error("load word disturbed the schedule");

  // The scan counter only moves while the candidate walks the cell row.
  a_cnt_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (cnt_r == '0))
    else $error("scan counter active outside the scan");

  // Once halted, results carry no completion and no miss.
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r && state_r == S_EMIT) |-> (!done_flag_r && !miss_flag_r))
    else $error("event flags raised while halted");

endmodule
